@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define SHAD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SHAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/shad_pkg.sv @@
// shared types, codes and the step function helpers for the scsi dma adapter
// no dependencies
package shad_pkg;

  // command codes
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_LINE   = 2'd2;

  // register selects
  localparam logic [2:0] REG_DATA   = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd1;
  localparam logic [2:0] REG_CTRL   = 3'd2;
  localparam logic [2:0] REG_ADDR_H = 3'd3;
  localparam logic [2:0] REG_ADDR_L = 3'd4;
  localparam logic [2:0] REG_COUNT  = 3'd5;

  // ack codes
  localparam logic [1:0] ACK_NONE    = 2'd0;
  localparam logic [1:0] ACK_ASSERT  = 2'd1;
  localparam logic [1:0] ACK_RELEASE = 2'd2;

  // control word bit positions
  localparam int CW_IRQEN = 0;
  localparam int CW_DMAEN = 1;
  localparam int CW_RST   = 4;
  localparam int CW_SEL   = 5;
  localparam int CW_BSY   = 6;
  localparam int CW_IO    = 8;
  localparam int CW_CD    = 9;
  localparam int CW_MSG   = 10;
  localparam int CW_REQ   = 11;
  localparam int CW_IRQ   = 12;
  localparam int CW_ODD   = 13;

  localparam logic [15:0] READ_MASK  = 16'hf80f;
  localparam logic [15:0] WRITE_MASK = 16'h003f;

  // scsi line bit positions
  localparam int LN_REQ = 0;
  localparam int LN_CD  = 1;
  localparam int LN_IO  = 2;
  localparam int LN_MSG = 3;
  localparam int LN_BSY = 4;
  localparam int LN_SEL = 5;
  localparam int LN_RST = 6;

  // bus phase as {msg, io, cd}
  localparam logic [2:0] PH_DATA_OUT = 3'b000;
  localparam logic [2:0] PH_DATA_IN  = 3'b010;
  localparam logic [2:0] PH_COMMAND  = 3'b001;
  localparam logic [2:0] PH_STATUS   = 3'b011;
  localparam logic [2:0] PH_MSG_OUT  = 3'b101;
  localparam logic [2:0] PH_MSG_IN   = 3'b111;

  localparam logic [15:0] DMA_STEP = 16'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  reg_select;
    logic [15:0] write_data;
    logic [6:0]  scsi_lines;
    logic [7:0]  scsi_data_in;
    logic [15:0] mem_read_data;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [7:0]  scsi_data_out;
    logic        scsi_data_valid;
    logic [1:0]  scsi_ack;
    logic        scsi_sel_out;
    logic        scsi_rst_out;
    logic        mem_write;
    logic        mem_read;
    logic [23:0] mem_addr;
    logic [15:0] mem_wdata;
    logic        irq_line;
  } result_t;

  typedef struct packed {
    logic [15:0] control_word;
    logic [23:0] dma_address;
    logic [15:0] byte_count;
    logic [15:0] word_buffer;
    logic        irq_level;
  } state_t;

  // change the irq bit; the line follows only while irq enable is set
  function automatic state_t set_irq(input state_t s, input logic on);
    state_t r;
    r = s;
    if (on != s.control_word[CW_IRQ]) begin
      r.control_word[CW_IRQ] = on;
      if (s.control_word[CW_IRQEN]) begin
        r.irq_level = on;
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/shad_if.sv @@
// valid/ready channel interfaces for the scsi dma adapter items and results
// no dependencies
interface shad_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  reg_select;
  logic [15:0] write_data;
  logic [6:0]  scsi_lines;
  logic [7:0]  scsi_data_in;
  logic [15:0] mem_read_data;

  modport source (output valid, command, reg_select, write_data, scsi_lines,
                  scsi_data_in, mem_read_data, input ready);
  modport sink (input valid, command, reg_select, write_data, scsi_lines,
                scsi_data_in, mem_read_data, output ready);
endinterface

interface shad_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [7:0]  scsi_data_out;
  logic        scsi_data_valid;
  logic [1:0]  scsi_ack;
  logic        scsi_sel_out;
  logic        scsi_rst_out;
  logic        mem_write;
  logic        mem_read;
  logic [23:0] mem_addr;
  logic [15:0] mem_wdata;
  logic        irq_line;

  modport source (output valid, read_data, scsi_data_out, scsi_data_valid, scsi_ack,
                  scsi_sel_out, scsi_rst_out, mem_write, mem_read, mem_addr,
                  mem_wdata, irq_line, input ready);
  modport sink (input valid, read_data, scsi_data_out, scsi_data_valid, scsi_ack,
                scsi_sel_out, scsi_rst_out, mem_write, mem_read, mem_addr,
                mem_wdata, irq_line, output ready);
endinterface

@@ hw/rtl/shad_step.sv @@
// combinational step: one item against the adapter state gives next state and result
// depends on shad_pkg
module shad_step import shad_pkg::*; (
  input  state_t  state,
  input  item_t   item,
  output state_t  state_next,
  output result_t result
);

  always_comb begin
    state_t      s;
    result_t     r;
    logic [6:0]  ln;
    logic [2:0]  ph;
    s  = state;
    r  = '0;
    ln = item.scsi_lines;
    ph = {ln[LN_MSG], ln[LN_IO], ln[LN_CD]};

    case (item.command)
      CMD_READ: begin
        case (item.reg_select)
          REG_DATA: r.read_data = {item.scsi_data_in, 8'h00};
          REG_STATUS: begin
            if (ln[LN_REQ] && ln[LN_CD] && ln[LN_IO]) begin
              s.control_word[CW_REQ] = 1'b0;
              r.scsi_ack = ACK_ASSERT;
              s = set_irq(s, 1'b0);
            end
          end
          REG_CTRL: begin
            r.read_data = s.control_word & READ_MASK;
            r.read_data[CW_RST] = ln[LN_RST];
            r.read_data[CW_SEL] = ln[LN_SEL];
            r.read_data[CW_BSY] = ln[LN_BSY];
            r.read_data[CW_IO]  = ln[LN_IO];
            r.read_data[CW_CD]  = ln[LN_CD];
            r.read_data[CW_MSG] = ln[LN_MSG];
          end
          REG_COUNT: r.read_data = s.byte_count;
          default: ;
        endcase
      end
      CMD_WRITE: begin
        case (item.reg_select)
          REG_DATA: begin
            r.scsi_data_out   = item.write_data[15:8];
            r.scsi_data_valid = 1'b1;
          end
          REG_STATUS: begin
            // command byte goes out only with req and cd up and io low (command or message out phase)
            if (ln[LN_REQ] && ln[LN_CD] && !ln[LN_IO]) begin
              s.control_word[CW_REQ] = 1'b0;
              r.scsi_data_out   = item.write_data[7:0];
              r.scsi_data_valid = 1'b1;
              r.scsi_ack        = ACK_ASSERT;
            end
          end
          REG_CTRL: s.control_word = (s.control_word & ~WRITE_MASK) |
                                     (item.write_data & WRITE_MASK);
          REG_ADDR_H: s.dma_address[23:16] = item.write_data[7:0];
          REG_ADDR_L: s.dma_address[15:0]  = item.write_data;
          REG_COUNT:  s.byte_count         = item.write_data;
          default: ;
        endcase
      end
      CMD_LINE: begin
        if (!s.control_word[CW_REQ] && ln[LN_REQ]) begin
          case (ph)
            PH_DATA_OUT, PH_DATA_IN: begin
              if (s.control_word[CW_DMAEN]) begin
                if (ln[LN_IO]) begin
                  // inbound: high byte first, write on the second byte
                  if (s.control_word[CW_ODD]) begin
                    s.word_buffer = s.word_buffer | {8'h00, item.scsi_data_in};
                  end else begin
                    s.word_buffer = {item.scsi_data_in, 8'h00};
                  end
                  s.control_word[CW_ODD] = !s.control_word[CW_ODD];
                  if (!s.control_word[CW_ODD]) begin
                    r.mem_write = 1'b1;
                    r.mem_addr  = s.dma_address;
                    r.mem_wdata = s.word_buffer;
                    s.dma_address = s.dma_address + 24'(DMA_STEP);
                    s.byte_count  = s.byte_count + DMA_STEP;
                  end
                end else begin
                  // outbound: fetch a word on the even byte
                  if (!s.control_word[CW_ODD]) begin
                    s.word_buffer = item.mem_read_data;
                    r.mem_read    = 1'b1;
                    r.mem_addr    = s.dma_address;
                    s.dma_address = s.dma_address + 24'(DMA_STEP);
                    s.byte_count  = s.byte_count + DMA_STEP;
                    r.scsi_data_out = s.word_buffer[15:8];
                  end else begin
                    r.scsi_data_out = s.word_buffer[7:0];
                  end
                  r.scsi_data_valid = 1'b1;
                  s.control_word[CW_ODD] = !s.control_word[CW_ODD];
                end
                r.scsi_ack = ACK_ASSERT;
              end else begin
                s = set_irq(s, 1'b1);
              end
            end
            PH_COMMAND: s.control_word[CW_REQ] = 1'b1;
            PH_STATUS, PH_MSG_OUT, PH_MSG_IN: begin
              s.control_word[CW_REQ] = 1'b1;
              s = set_irq(s, 1'b1);
            end
            default: ;  // reserved phases
          endcase
        end else begin
          r.scsi_ack = ACK_RELEASE;
        end
      end
      default: ;
    endcase

    r.scsi_sel_out = s.control_word[CW_SEL];
    r.scsi_rst_out = s.control_word[CW_RST];
    r.irq_line     = s.irq_level;
    state_next = s;
    result     = r;
  end

endmodule

@@ hw/rtl/scsi_host_adapter_dma_unit.sv @@
// an input transfer reaches the result channel through the input and result registers
// one item per cycle while results are taken; the state update sits between the two registers
// an input transfer is taken while a result waits only if the input register is empty
// reset: rst_n synchronous active low; clears both valid flags and all adapter state
// (control word, dma address, count, word buffer, irq line) to zero
// depends on shad_pkg, shad_if and shad_step
module scsi_host_adapter_dma_unit import shad_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  shad_in_if.sink    in_ch,
  shad_out_if.source out_ch
);

  // input register
  logic    in_valid_r, in_valid_nxt;
  item_t   in_item_r;
  // result register
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  // adapter state
  state_t  state_r;
  state_t  state_step;
  result_t res_step;

  logic in_xfer;
  logic step_fire;

  // the step runs when the result register is free or being emptied
  assign step_fire = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step_fire;
  assign in_xfer = in_ch.valid && in_ch.ready;

  shad_step u_step (
    .state      (state_r),
    .item       (in_item_r),
    .state_next (state_step),
    .result     (res_step)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (step_fire) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and adapter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step_fire) begin
        state_r <= state_step;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r.command       <= in_ch.command;
      in_item_r.reg_select    <= in_ch.reg_select;
      in_item_r.write_data    <= in_ch.write_data;
      in_item_r.scsi_lines    <= in_ch.scsi_lines;
      in_item_r.scsi_data_in  <= in_ch.scsi_data_in;
      in_item_r.mem_read_data <= in_ch.mem_read_data;
    end
    if (step_fire) begin
      out_res_r <= res_step;
    end
  end

  // result channel
  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = out_res_r.read_data;
  assign out_ch.scsi_data_out   = out_res_r.scsi_data_out;
  assign out_ch.scsi_data_valid = out_res_r.scsi_data_valid;
  assign out_ch.scsi_ack        = out_res_r.scsi_ack;
  assign out_ch.scsi_sel_out    = out_res_r.scsi_sel_out;
  assign out_ch.scsi_rst_out    = out_res_r.scsi_rst_out;
  assign out_ch.mem_write       = out_res_r.mem_write;
  assign out_ch.mem_read        = out_res_r.mem_read;
  assign out_ch.mem_addr        = out_res_r.mem_addr;
  assign out_ch.mem_wdata       = out_res_r.mem_wdata;
  assign out_ch.irq_line        = out_res_r.irq_line;

endmodule

@@ hw/rtl/shad_checker.sv @@
// port-level checks on the scsi dma adapter result channel, bound to the top level
// depends on shad_pkg and assert_macros.svh
`include "assert_macros.svh"

module shad_checker import shad_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_scsi_data_out,
  input logic        out_scsi_data_valid,
  input logic [1:0]  out_scsi_ack,
  input logic        out_mem_write,
  input logic        out_mem_read,
  input logic [23:0] out_mem_addr,
  input logic [15:0] out_mem_wdata
);

  // stalled transfer keeps its memory address and ack code
  `SHAD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_mem_addr) && $stable(out_scsi_ack), "result changed while stalled")
  // a dma byte moves one way only
  `SHAD_ASSERT(a_mem_dir, clk, rst_n, out_valid |-> !(out_mem_write && out_mem_read), "memory read and write in one result")
  // no memory access means no address and no write word
  `SHAD_ASSERT(a_mem_idle, clk, rst_n, out_valid && !out_mem_write && !out_mem_read |-> out_mem_addr == 24'd0 && out_mem_wdata == 16'd0, "memory fields set without access")
  // undriven data lines read zero, ack code stays in range
  `SHAD_ASSERT(a_data_ack, clk, rst_n, out_valid |-> (out_scsi_data_valid || out_scsi_data_out == 8'd0) && (out_scsi_ack == ACK_NONE || out_scsi_ack == ACK_ASSERT || out_scsi_ack == ACK_RELEASE), "bad data or ack field")

endmodule

bind scsi_host_adapter_dma_unit shad_checker u_shad_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_scsi_data_out   (out_ch.scsi_data_out),
  .out_scsi_data_valid (out_ch.scsi_data_valid),
  .out_scsi_ack        (out_ch.scsi_ack),
  .out_mem_write       (out_ch.mem_write),
  .out_mem_read        (out_ch.mem_read),
  .out_mem_addr        (out_ch.mem_addr),
  .out_mem_wdata       (out_ch.mem_wdata)
);

@@ tb/sv/scsi_host_adapter_dma_unit_tb.sv @@
// self-checking testbench for the scsi host adapter with word dma
// depends on shad_pkg, shad_if and the scsi_host_adapter_dma_unit rtl
// drives register accesses and bus events, predicts every result and compares them
module scsi_host_adapter_dma_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import shad_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [2:0] REG_UNUSED_6 = 3'd6;
  localparam logic [2:0] REG_UNUSED_7 = 3'd7;
  // reserved bus phases as {msg, io, cd}
  localparam logic [2:0] PH_RSV_MSG    = 3'b100;
  localparam logic [2:0] PH_RSV_MSG_IO = 3'b110;

  localparam int IDLE_LIMIT  = 5000;  // cycles without any transfer before giving up
  localparam int LONG_HOLD   = 400;   // receiver hold-off, long enough to back up the input
  localparam int CHUNK_ITEMS = 400;   // random items per phase, four phases

  logic clk;
  logic rst_n;

  shad_in_if  in_ch ();
  shad_out_if out_ch ();

  scsi_host_adapter_dma_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // items waiting for the driver, results waiting for the monitor
  item_t   host_items[$];
  result_t due_results[$];
  int      items_queued = 0;
  int      mismatches = 0;
  logic    hold_request = 1'b0;

  // predicted adapter state
  logic [15:0] ctl_word;
  logic [23:0] dma_addr;
  logic [15:0] xfer_count;
  logic [15:0] byte_pair;
  logic        irq_out;

  // the irq bit always follows, the line only while irq enable is set
  function automatic void drive_irq(input logic on);
    if (on != ctl_word[CW_IRQ]) begin
      ctl_word[CW_IRQ] = on;
      if (ctl_word[CW_IRQEN]) begin
        irq_out = on;
      end
    end
  endfunction

  // one word moved: address wraps at 24 bits, count at 16
  function automatic void advance_dma();
    dma_addr   = dma_addr + 24'd2;
    xfer_count = xfer_count + DMA_STEP;
  endfunction

  // expected result of one accepted item, updating the predicted state
  function automatic result_t adapter_result(input item_t it);
    result_t    r;
    logic [2:0] ph;
    logic [6:0] ln;
    r  = '0;
    ln = it.scsi_lines;
    ph = {ln[LN_MSG], ln[LN_IO], ln[LN_CD]};
    case (it.command)
      CMD_READ: begin
        case (it.reg_select)
          REG_DATA: r.read_data = {it.scsi_data_in, 8'h00};
          REG_STATUS: begin
            // status read answers a req in status or message in phase
            if (ln[LN_REQ] && ln[LN_CD] && ln[LN_IO]) begin
              ctl_word[CW_REQ] = 1'b0;
              r.scsi_ack = ACK_ASSERT;
              drive_irq(1'b0);
            end
          end
          REG_CTRL: begin
            // masked-out bits show the live bus lines, but bit 7 reads zero
            r.read_data = ctl_word & READ_MASK;
            r.read_data[CW_RST] = ln[LN_RST];
            r.read_data[CW_SEL] = ln[LN_SEL];
            r.read_data[CW_BSY] = ln[LN_BSY];
            r.read_data[CW_IO]  = ln[LN_IO];
            r.read_data[CW_CD]  = ln[LN_CD];
            r.read_data[CW_MSG] = ln[LN_MSG];
          end
          REG_COUNT: r.read_data = xfer_count;
          default: ;
        endcase
      end
      CMD_WRITE: begin
        case (it.reg_select)
          REG_DATA: begin
            r.scsi_data_out   = it.write_data[15:8];
            r.scsi_data_valid = 1'b1;
          end
          REG_STATUS: begin
            // command byte goes out only in a command-type phase
            if (ln[LN_REQ] && ln[LN_CD] && !ln[LN_IO]) begin
              ctl_word[CW_REQ]  = 1'b0;
              r.scsi_data_out   = it.write_data[7:0];
              r.scsi_data_valid = 1'b1;
              r.scsi_ack        = ACK_ASSERT;
            end
          end
          REG_CTRL:   ctl_word = (ctl_word & ~WRITE_MASK) | (it.write_data & WRITE_MASK);
          REG_ADDR_H: dma_addr[23:16] = it.write_data[7:0];
          REG_ADDR_L: dma_addr[15:0] = it.write_data;
          REG_COUNT:  xfer_count = it.write_data;
          default: ;
        endcase
      end
      CMD_LINE: begin
        if (!ctl_word[CW_REQ] && ln[LN_REQ]) begin
          case (ph)
            PH_DATA_OUT, PH_DATA_IN: begin
              if (ctl_word[CW_DMAEN]) begin
                if (ln[LN_IO]) begin
                  // inbound: high byte first, word written on the second byte
                  if (ctl_word[CW_ODD]) begin
                    byte_pair = byte_pair | {8'h00, it.scsi_data_in};
                  end else begin
                    byte_pair = {it.scsi_data_in, 8'h00};
                  end
                  ctl_word[CW_ODD] = ~ctl_word[CW_ODD];
                  if (!ctl_word[CW_ODD]) begin
                    r.mem_write = 1'b1;
                    r.mem_addr  = dma_addr;
                    r.mem_wdata = byte_pair;
                    advance_dma();
                  end
                end else begin
                  // outbound: fetch a word on the even byte, send high then low
                  if (!ctl_word[CW_ODD]) begin
                    byte_pair       = it.mem_read_data;
                    r.mem_read      = 1'b1;
                    r.mem_addr      = dma_addr;
                    advance_dma();
                    r.scsi_data_out = byte_pair[15:8];
                  end else begin
                    r.scsi_data_out = byte_pair[7:0];
                  end
                  r.scsi_data_valid = 1'b1;
                  ctl_word[CW_ODD] = ~ctl_word[CW_ODD];
                end
                r.scsi_ack = ACK_ASSERT;
              end else begin
                drive_irq(1'b1);
              end
            end
            PH_COMMAND: ctl_word[CW_REQ] = 1'b1;
            PH_STATUS, PH_MSG_OUT, PH_MSG_IN: begin
              ctl_word[CW_REQ] = 1'b1;
              drive_irq(1'b1);
            end
            default: ;  // reserved phases do nothing
          endcase
        end else begin
          r.scsi_ack = ACK_RELEASE;
        end
      end
      default: ;
    endcase
    r.scsi_sel_out = ctl_word[CW_SEL];
    r.scsi_rst_out = ctl_word[CW_RST];
    r.irq_line     = irq_out;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- driver
  // offers queued items in bursts of random length with random gaps
  item_t offered;
  int    burst_left;
  int    gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
      ctl_word   = '0;
      dma_addr   = '0;
      xfer_count = '0;
      byte_pair  = '0;
      irq_out    = 1'b0;
    end else begin
      // input transfer: predict its result now, in acceptance order
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(adapter_result(offered));
      end
      // valid only moves when nothing is offered or the offer was just taken
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (host_items.size() > 0) begin
          offered = host_items.pop_front();
          in_ch.command       <= offered.command;
          in_ch.reg_select    <= offered.reg_select;
          in_ch.write_data    <= offered.write_data;
          in_ch.scsi_lines    <= offered.scsi_lines;
          in_ch.scsi_data_in  <= offered.scsi_data_in;
          in_ch.mem_read_data <= offered.mem_read_data;
          in_ch.valid         <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // new burst; a third of the bursts run back to back
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  // checks each result transfer and stalls on a rotating pattern of its own
  logic [31:0] rx_tick;
  int          hold_left;
  logic        hold_done;

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_tick   = '0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected", $time);
        end else begin
          want = due_results.pop_front();
          check_field("read_data",       24'(want.read_data),       24'(out_ch.read_data));
          check_field("scsi_data_out",   24'(want.scsi_data_out),   24'(out_ch.scsi_data_out));
          check_field("scsi_data_valid", 24'(want.scsi_data_valid),
                      24'(out_ch.scsi_data_valid));
          check_field("scsi_ack",        24'(want.scsi_ack),        24'(out_ch.scsi_ack));
          check_field("scsi_sel_out",    24'(want.scsi_sel_out),    24'(out_ch.scsi_sel_out));
          check_field("scsi_rst_out",    24'(want.scsi_rst_out),    24'(out_ch.scsi_rst_out));
          check_field("mem_write",       24'(want.mem_write),       24'(out_ch.mem_write));
          check_field("mem_read",        24'(want.mem_read),        24'(out_ch.mem_read));
          check_field("mem_addr",        want.mem_addr,             out_ch.mem_addr);
          check_field("mem_wdata",       24'(want.mem_wdata),       24'(out_ch.mem_wdata));
          check_field("irq_line",        24'(want.irq_line),        24'(out_ch.irq_line));
        end
      end
      rx_tick = rx_tick + 1;
      // one long hold-off so the pipeline fills and the input backs up
      if (hold_request && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_tick[8:7])
          2'd0:    out_ch.ready <= 1'b1;
          2'd1:    out_ch.ready <= ($urandom_range(0, 3) != 0);
          2'd2:    out_ch.ready <= (rx_tick[2:0] != 3'd5);
          default: out_ch.ready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic void queue_item(input logic [1:0] c, input logic [2:0] s,
                                     input logic [15:0] wd, input logic [6:0] ln,
                                     input logic [7:0] din, input logic [15:0] mrd);
    item_t it;
    it.command       = c;
    it.reg_select    = s;
    it.write_data    = wd;
    it.scsi_lines    = ln;
    it.scsi_data_in  = din;
    it.mem_read_data = mrd;
    host_items.push_back(it);
    items_queued++;
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom());
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom());
  endfunction

  function automatic logic [2:0] rnd_sel();
    return 3'($urandom_range(0, 7));
  endfunction

  // bus lines for a phase, with random rst/sel/bsy on top
  function automatic logic [6:0] scsi_bus(input logic [2:0] ph, input logic req);
    logic [2:0] side;
    side = 3'($urandom_range(0, 7));
    return {side, ph[2], ph[1], ph[0], req};
  endfunction

  // bus event with random payload in the ignored fields
  function automatic void bus_event(input logic [2:0] ph, input logic req);
    queue_item(CMD_LINE, rnd_sel(), rnd16(), scsi_bus(ph, req), rnd8(), rnd16());
  endfunction

  // a status read in status phase drops any req latch and the irq bit
  function automatic void clear_latch();
    queue_item(CMD_READ, REG_STATUS, rnd16(), scsi_bus(PH_STATUS, 1'b1), rnd8(), rnd16());
  endfunction

  task automatic directed_items();
    // control read with every line high, then all host bits set
    queue_item(CMD_READ,  REG_CTRL,   16'h0000, 7'h7f, 8'h00, 16'h0000);
    queue_item(CMD_WRITE, REG_CTRL,   16'hffff, 7'h00, 8'hff, 16'hffff);
    // dma pointer at the very top so the first word wraps both
    queue_item(CMD_WRITE, REG_ADDR_H, 16'hffff, 7'h00, 8'h00, 16'h0000);
    queue_item(CMD_WRITE, REG_ADDR_L, 16'hfffe, 7'h00, 8'h00, 16'h0000);
    queue_item(CMD_WRITE, REG_COUNT,  16'hfffe, 7'h00, 8'h00, 16'h0000);
    queue_item(CMD_READ,  REG_COUNT,  16'h0000, 7'h00, 8'h00, 16'h0000);
    // write-only address register, unused selects and the unused command
    queue_item(CMD_READ,  REG_ADDR_H,   16'h0000, 7'h00, 8'h00, 16'h0000);
    queue_item(CMD_READ,  REG_UNUSED_6, 16'hffff, 7'h7f, 8'hff, 16'hffff);
    queue_item(CMD_WRITE, REG_UNUSED_7, 16'hffff, 7'h7f, 8'hff, 16'hffff);
    queue_item(CMD_UNUSED, REG_CTRL,    16'hffff, 7'h7f, 8'hff, 16'hffff);
    queue_item(CMD_READ,  REG_DATA,   16'h0000, 7'h00, 8'hff, 16'h0000);
    queue_item(CMD_WRITE, REG_DATA,   16'hff00, 7'h00, 8'h00, 16'h0000);
    // inbound dma word, req dropped in between
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h05, 8'ha5, 16'h0000);
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h04, 8'h00, 16'h0000);
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h05, 8'h5a, 16'h0000);
    // outbound dma word
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h01, 8'h00, 16'hbeef);
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h01, 8'h00, 16'h0000);
    // command phase: latch, event while latched, command byte, write outside phase
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h03, 8'h00, 16'h0000);
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h03, 8'h00, 16'h0000);
    queue_item(CMD_WRITE, REG_STATUS, 16'h12c3, 7'h03, 8'h00, 16'h0000);
    queue_item(CMD_WRITE, REG_STATUS, 16'h00ff, 7'h00, 8'h00, 16'h0000);
    // status phase raises irq, status read answers it
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h07, 8'h00, 16'h0000);
    queue_item(CMD_READ,  REG_STATUS, 16'h0000, 7'h07, 8'h00, 16'h0000);
    // reserved phases, then message out answered by a command write
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h09, 8'h00, 16'h0000);
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h0d, 8'h00, 16'h0000);
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h0b, 8'h00, 16'h0000);
    queue_item(CMD_WRITE, REG_STATUS, 16'h0077, 7'h0b, 8'h00, 16'h0000);
    // irq raised with enable off, enable turned on later, then cleared
    queue_item(CMD_WRITE, REG_CTRL,   16'h0000, 7'h00, 8'h00, 16'h0000);
    queue_item(CMD_LINE,  REG_DATA,   16'h0000, 7'h01, 8'h00, 16'h0000);
    queue_item(CMD_WRITE, REG_CTRL,   16'h0001, 7'h00, 8'h00, 16'h0000);
    queue_item(CMD_READ,  REG_STATUS, 16'h0000, 7'h0f, 8'h00, 16'h0000);
  endtask

  // one random sequence; mostly well-formed bus traffic, some noise
  task automatic random_sequence();
    int         kind;
    int         n;
    logic [2:0] ph;
    logic [2:0] odd_phases[5];
    odd_phases = '{PH_STATUS, PH_MSG_IN, PH_MSG_OUT, PH_RSV_MSG, PH_RSV_MSG_IO};
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3, 4: begin
        // dma stream, inbound or outbound, with an optional new pointer
        clear_latch();
        if ($urandom_range(0, 1) == 1) begin
          queue_item(CMD_WRITE, REG_ADDR_H, rnd16(), scsi_bus(rnd_sel(), 1'b0), rnd8(), rnd16());
          queue_item(CMD_WRITE, REG_ADDR_L, rnd16(), scsi_bus(rnd_sel(), 1'b0), rnd8(), rnd16());
          queue_item(CMD_WRITE, REG_COUNT,  rnd16(), scsi_bus(rnd_sel(), 1'b0), rnd8(), rnd16());
        end
        queue_item(CMD_WRITE, REG_CTRL, rnd16() | (16'd1 << CW_DMAEN), scsi_bus(rnd_sel(), 1'b0),
                   rnd8(), rnd16());
        ph = (kind < 3) ? PH_DATA_IN : PH_DATA_OUT;
        n  = $urandom_range(1, 12);
        repeat (n) begin
          bus_event(ph, 1'b1);
          if ($urandom_range(0, 2) != 0) begin
            bus_event(ph, 1'b0);
          end
        end
        if ($urandom_range(0, 1) == 1) begin
          queue_item(CMD_READ, REG_COUNT, rnd16(), scsi_bus(rnd_sel(), 1'b0), rnd8(), rnd16());
        end
      end
      5: begin
        // data phase without dma raises irq, a status read mostly clears it
        clear_latch();
        queue_item(CMD_WRITE, REG_CTRL, rnd16() & ~(16'd1 << CW_DMAEN),
                   scsi_bus(rnd_sel(), 1'b0), rnd8(), rnd16());
        bus_event(($urandom_range(0, 1) == 1) ? PH_DATA_IN : PH_DATA_OUT, 1'b1);
        bus_event(PH_DATA_IN, 1'b0);
        if ($urandom_range(0, 3) != 0) begin
          clear_latch();
        end
      end
      6: begin
        // command phase, sometimes with events while latched or a stray write
        bus_event(PH_COMMAND, 1'b1);
        if ($urandom_range(0, 1) == 1) begin
          bus_event(rnd_sel(), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 3) == 0) begin
          queue_item(CMD_WRITE, REG_STATUS, rnd16(), scsi_bus(PH_DATA_OUT, 1'b1),
                     rnd8(), rnd16());
        end
        queue_item(CMD_WRITE, REG_STATUS, rnd16(), scsi_bus(PH_COMMAND, 1'b1), rnd8(), rnd16());
      end
      7: begin
        // status, message and reserved phases
        ph = odd_phases[$urandom_range(0, 4)];
        bus_event(ph, 1'b1);
        if (ph == PH_MSG_OUT) begin
          queue_item(CMD_WRITE, REG_STATUS, rnd16(), scsi_bus(PH_MSG_OUT, 1'b1), rnd8(), rnd16());
        end
        queue_item(CMD_READ, REG_STATUS, rnd16(), scsi_bus(ph, 1'b1), rnd8(), rnd16());
        bus_event(ph, 1'b0);
      end
      8: begin
        // plain register traffic
        n = $urandom_range(1, 4);
        repeat (n) begin
          queue_item(2'($urandom_range(0, 1)), 3'($urandom_range(0, 5)), rnd16(),
                     7'($urandom()), rnd8(), rnd16());
        end
      end
      default: begin
        // noise over the whole field space
        n = $urandom_range(1, 4);
        repeat (n) begin
          queue_item(2'($urandom_range(0, 3)), rnd_sel(), rnd16(), 7'($urandom()),
                     rnd8(), rnd16());
        end
      end
    endcase
  endtask

  // hold the sender until every queued item has come back checked
  task automatic drain();
    while (host_items.size() != 0 || in_ch.valid || due_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------- main sequence
  initial begin
    int target;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = '0;
    in_ch.reg_select    = '0;
    in_ch.write_data    = '0;
    in_ch.scsi_lines    = '0;
    in_ch.scsi_data_in  = '0;
    in_ch.mem_read_data = '0;
    out_ch.ready        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_items();
    drain();

    // random phases; the second starts with the long receiver hold-off
    for (int chunk = 0; chunk < 4; chunk++) begin
      if (chunk == 1) begin
        hold_request = 1'b1;
      end
      target = items_queued + CHUNK_ITEMS;
      while (items_queued < target) begin
        random_sequence();
      end
      drain();
    end

    // allow for the two-stage pipeline to show any stray result
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/shad_pkg.sv
hw/rtl/shad_if.sv
hw/rtl/shad_step.sv
hw/rtl/scsi_host_adapter_dma_unit.sv
hw/rtl/shad_checker.sv
tb/sv/scsi_host_adapter_dma_unit_tb.sv
